// ===== sv/mtet_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-turn encoder tracker: item types, command codes,
// register map and constants. No dependencies.
package mtet_pkg;

	// encoder geometry
	localparam int ANGLE_W   = 13;
	localparam int RATE_W    = 14;
	localparam int WORD_W    = 16;
	localparam int POS_W     = 30;
	localparam int SETTLE_W  = 7;
	localparam int FUNC_W    = 2;
	localparam int HALF_TURN = 4096;
	localparam int FULL_TURN = 8192;

	// defaults
	localparam int TURN_BITS_DEF   = 16;
	localparam int SETTLE_RST      = 50;
	localparam int QUEUE_DEPTH_DEF = 2;

	// configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_SETTLE = 2'd0;

	// command codes carried in func
	typedef enum logic [FUNC_W-1:0] {
		FUNC_FRAME  = 2'd0,
		FUNC_RESET  = 2'd1,
		FUNC_ZERO   = 2'd2,
		FUNC_UNUSED = 2'd3
	} func_t;

	// decoded operation, at most one bit set
	typedef struct packed {
		logic frame;
		logic reset_pos;
		logic zero_off;
	} op_t;

	// item handed from the front to the back
	typedef struct packed {
		op_t                      op;
		logic [ANGLE_W-1:0]       angle;
		logic signed [WORD_W-1:0] speed;
		logic signed [WORD_W-1:0] current;
	} cmd_t;

	// result item
	typedef struct packed {
		logic signed [POS_W-1:0]  total_position;
		logic signed [RATE_W-1:0] angle_rate;
		logic signed [WORD_W-1:0] turn_count;
		logic signed [WORD_W-1:0] motor_speed;
		logic signed [WORD_W-1:0] motor_current;
		logic                     tracking;
	} res_t;

endpackage

// ===== sv/mtet_fifo.sv =====
`timescale 1ns / 1ps
// Small register-based FIFO used between the pipeline parts.
// Depends on nothing.
module mtet_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/mtet_front.sv =====
`timescale 1ns / 1ps
// Front part: decodes func of each incoming item and queues it for the back.
// Depends on mtet_pkg and mtet_fifo.
module mtet_front import mtet_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [FUNC_W-1:0]        func,
	input  logic [ANGLE_W-1:0]       encoder_angle,
	input  logic signed [WORD_W-1:0] speed_in,
	input  logic signed [WORD_W-1:0] current_in,
	input  logic                     cmd_pop,
	output cmd_t                     cmd,
	output logic                     cmd_empty
);
	cmd_t                cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	// classify the command
	always_comb begin
		cmd_in.op      = '0;
		cmd_in.angle   = encoder_angle;
		cmd_in.speed   = speed_in;
		cmd_in.current = current_in;
		unique case (func_t'(func))
			FUNC_FRAME:  cmd_in.op.frame     = 1'b1;
			FUNC_RESET:  cmd_in.op.reset_pos = 1'b1;
			FUNC_ZERO:   cmd_in.op.zero_off  = 1'b1;
			FUNC_UNUSED: cmd_in.op           = '0;
			default:     cmd_in.op           = '0;
		endcase
	end

	// decoupling queue toward the back
	mtet_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_raw),
		.empty  (cmd_empty)
	);

	assign cmd = cmd_t'(cmd_raw);

endmodule

// ===== sv/mtet_back.sv =====
`timescale 1ns / 1ps
// Back part: tracker state, angle unwrap and result queue.
// Depends on mtet_pkg and mtet_fifo.
module mtet_back import mtet_pkg::*; #(
	parameter int TURN_BITS = TURN_BITS_DEF,
	parameter int DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SETTLE_W-1:0] settle_frames,
	input  cmd_t                cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	input  logic                res_pop,
	output res_t                res,
	output logic                res_empty
);
	localparam int EXT_W = POS_W - ANGLE_W;

	// tracker state
	logic [SETTLE_W-1:0]      frame_count_q;
	logic                     settled_q;
	logic [ANGLE_W-1:0]       cur_angle_q;
	logic [ANGLE_W-1:0]       off_angle_q;
	logic [TURN_BITS-1:0]     turns_q;
	logic signed [RATE_W-1:0] rate_q;
	logic signed [WORD_W-1:0] speed_q;
	logic signed [WORD_W-1:0] current_q;

	// next state
	logic [SETTLE_W-1:0]      frame_count_d;
	logic                     settled_d;
	logic [ANGLE_W-1:0]       cur_angle_d;
	logic [ANGLE_W-1:0]       off_angle_d;
	logic [TURN_BITS-1:0]     turns_d;
	logic signed [RATE_W-1:0] rate_d;
	logic signed [WORD_W-1:0] speed_d;
	logic signed [WORD_W-1:0] current_d;

	logic [SETTLE_W:0]        next_count;
	logic signed [RATE_W:0]   diff;
	logic [EXT_W-1:0]         turns_ext;
	logic [WORD_W-1:0]        turns_out;
	logic                     res_full;
	logic                     step;
	res_t                     res_in;
	logic [$bits(res_t)-1:0]  res_raw;

	assign step    = !cmd_empty && !res_full;
	assign cmd_pop = step;

	assign next_count = {1'b0, frame_count_q} + 1'b1;
	assign diff = $signed({2'b00, cmd.angle}) - $signed({2'b00, cur_angle_q});

	// state update for one item
	always_comb begin
		frame_count_d = frame_count_q;
		settled_d     = settled_q;
		cur_angle_d   = cur_angle_q;
		off_angle_d   = off_angle_q;
		turns_d       = turns_q;
		rate_d        = rate_q;
		speed_d       = speed_q;
		current_d     = current_q;
		if (cmd.op.frame) begin
			settled_d     = settled_q || (next_count > {1'b0, settle_frames});
			frame_count_d = next_count[SETTLE_W] ? '1 : next_count[SETTLE_W-1:0];
			cur_angle_d   = cmd.angle;
			if (!settled_d) begin
				off_angle_d = cmd.angle;
			end else begin
				speed_d   = cmd.speed;
				current_d = cmd.current;
				priority if (diff > (RATE_W+1)'(HALF_TURN)) begin
					turns_d = turns_q - 1'b1;
					rate_d  = RATE_W'(diff - (RATE_W+1)'(FULL_TURN));
				end else if (diff < -(RATE_W+1)'(HALF_TURN)) begin
					turns_d = turns_q + 1'b1;
					rate_d  = RATE_W'(diff + (RATE_W+1)'(FULL_TURN));
				end else begin
					rate_d  = RATE_W'(diff);
				end
			end
		end else if (cmd.op.reset_pos) begin
			off_angle_d = cur_angle_q;
			turns_d     = '0;
		end else if (cmd.op.zero_off) begin
			off_angle_d = '0;
		end
	end

	// turn count sized for the position sum (sign-extended or cut) and for the turn output (zero-padded or cut)
	generate
		if (TURN_BITS >= EXT_W) begin : g_ext_cut
			assign turns_ext = turns_d[EXT_W-1:0];
		end else begin : g_ext_sign
			assign turns_ext = {{(EXT_W - TURN_BITS){turns_d[TURN_BITS-1]}}, turns_d};
		end
		if (TURN_BITS >= WORD_W) begin : g_out_cut
			assign turns_out = turns_d[WORD_W-1:0];
		end else begin : g_out_pad
			assign turns_out = {{(WORD_W - TURN_BITS){1'b0}}, turns_d};
		end
	endgenerate

	// result from the state after the item
	always_comb begin
		res_in.total_position = $signed({turns_ext, {ANGLE_W{1'b0}}}
			+ {{EXT_W{1'b0}}, cur_angle_d} - {{EXT_W{1'b0}}, off_angle_d});
		res_in.angle_rate     = rate_d;
		res_in.turn_count     = $signed(turns_out);
		res_in.motor_speed    = speed_d;
		res_in.motor_current  = current_d;
		res_in.tracking       = settled_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			settled_q     <= 1'b0;
			cur_angle_q   <= '0;
			off_angle_q   <= '0;
			turns_q       <= '0;
			rate_q        <= '0;
			speed_q       <= '0;
			current_q     <= '0;
		end else if (step) begin
			frame_count_q <= frame_count_d;
			settled_q     <= settled_d;
			cur_angle_q   <= cur_angle_d;
			off_angle_q   <= off_angle_d;
			turns_q       <= turns_d;
			rate_q        <= rate_d;
			speed_q       <= speed_d;
			current_q     <= current_d;
		end
	end

	// result queue toward the consumer
	mtet_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.din    (res_in),
		.full   (res_full),
		.pop    (res_pop),
		.dout   (res_raw),
		.empty  (res_empty)
	);

	assign res = res_t'(res_raw);

endmodule

// ===== sv/multi_turn_encoder_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the multi-turn encoder tracker: APB register and the two parts.
// Depends on mtet_pkg, mtet_front and mtet_back.
//
//   port group   | kind       | accepted when
//   -------------+------------+------------------------------------------
//   item in      | queue push | push && !full
//   result out   | queue pop  | pop && !empty
//   config       | APB write  | psel && penable && pwrite (pready tied 1)
//
// One item per cycle sustained while the result queue is not full. An accepted
// item waits in the input queue; the state update takes it from there and
// writes its result into the result queue at the same edge, from which it can be popped.
// Reset clears all tracker state, the queues and sets settle_frames to 50.
// A full result queue stalls the back; the input queue keeps taking items
// until it is full too.
module multi_turn_encoder_tracker import mtet_pkg::*; #(
	parameter int TURN_BITS   = TURN_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// item channel
	input  logic                     push,
	output logic                     full,
	input  logic [FUNC_W-1:0]        func,
	input  logic [ANGLE_W-1:0]       encoder_angle,
	input  logic signed [WORD_W-1:0] speed_in,
	input  logic signed [WORD_W-1:0] current_in,
	// result channel
	output logic                     empty,
	input  logic                     pop,
	output logic signed [POS_W-1:0]  total_position,
	output logic signed [RATE_W-1:0] angle_rate,
	output logic signed [WORD_W-1:0] turn_count,
	output logic signed [WORD_W-1:0] motor_speed,
	output logic signed [WORD_W-1:0] motor_current,
	output logic                     tracking,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready
);
	logic [SETTLE_W-1:0] settle_q;
	cmd_t                cmd;
	logic                cmd_empty;
	logic                cmd_pop;
	res_t                res;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(SETTLE_RST);
		end else if (psel && penable && pwrite && pready && paddr == ADDR_SETTLE) begin
			settle_q <= pwdata[SETTLE_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_SETTLE) ? {{(PDATA_W - SETTLE_W){1'b0}}, settle_q} : '0;

	// front: accept and classify
	mtet_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.func          (func),
		.encoder_angle (encoder_angle),
		.speed_in      (speed_in),
		.current_in    (current_in),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd),
		.cmd_empty     (cmd_empty)
	);

	// back: unwrap and report
	mtet_back #(
		.TURN_BITS (TURN_BITS),
		.DEPTH     (QUEUE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.settle_frames (settle_q),
		.cmd           (cmd),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.res_pop       (pop),
		.res           (res),
		.res_empty     (empty)
	);

	assign total_position = res.total_position;
	assign angle_rate     = res.angle_rate;
	assign turn_count     = res.turn_count;
	assign motor_speed    = res.motor_speed;
	assign motor_current  = res.motor_current;
	assign tracking       = res.tracking;

endmodule
